FILE: rtl/core/mprq_pkg.sv
package mprq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_W          = 8;
   localparam int PRIO_W        = 8;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ   = 2'd0,
      OP_DEQ   = 2'd1,
      OP_PURGE = 2'd2,
      OP_NOP   = 2'd3
   } op_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_REMOVE,
      S_INSERT,
      S_DONE
   } fsm_state_type;

endpackage

FILE: rtl/core/mprq_cell.sv
module mprq_cell
   import mprq_pkg::*;
(
   input  logic      clock,
   input  logic      shift_en,
   input  entry_type d_next,
   output entry_type q
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = shift_en ? d_next : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

FILE: rtl/core/min_priority_ready_queue_unit.sv
// enqueue and purge make one pass around the ring of cells, dequeue makes a scan pass
//   and then a remove pass; full, empty and no-op requests go straight to the response
// one request at a time: the next request is accepted only after the response of the last
//   one has been registered; a pass turns the ring once and does not wait on the output,
//   but the response is held back while an earlier response waits to be taken
// reset: synchronous active high, empties the queue; slot contents are not cleared
module min_priority_ready_queue_unit
   import mprq_pkg::*;
#(
   parameter  int QUEUE_DEPTH = DEPTH_DEFAULT,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W       = ((ID_W + PRIO_W + CNT_W + 1 + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,  // proc_id, prio
   input  logic [OP_W-1:0]     req_tuser,  // req_type
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,  // out_id, out_prio, entry_count, is_empty
   output logic [STATUS_W-1:0] rsp_tuser   // status
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   fsm_state_type state_ff, state_in;
   op_code_type   op_ff, op_in;
   entry_type     key_ff, key_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic          found_ff, found_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type    res_status_ff, res_status_in;
   entry_type     res_entry_ff, res_entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   status_type    rsp_status_ff, rsp_status_in;

   entry_type cell_q    [QUEUE_DEPTH];
   entry_type cell_next [QUEUE_DEPTH];
   logic      cell_en   [QUEUE_DEPTH];

   entry_type head;
   entry_type tail_src;
   logic      accept;
   logic      last_step;
   logic      step_live;
   logic      shift_en;
   logic      short_ring;
   logic      drop_now;
   logic      out_free;
   op_code_type req_op;

   assign head       = cell_q[0];
   assign req_op     = op_code_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign last_step  = (step_ff == LAST_STEP);
   assign step_live  = (CNT_W'(step_ff) < count_ff);
   assign shift_en   = (state_ff == S_SCAN) || (state_ff == S_REMOVE) ||
                       (state_ff == S_INSERT);
   assign short_ring = (state_ff == S_REMOVE) && found_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      drop_now = 1'b0;
      if (state_ff == S_REMOVE && !found_ff) begin
         if (op_ff == OP_DEQ) begin
            drop_now = (step_ff == best_idx_ff);
         end else begin
            drop_now = step_live && (head.id == key_ff.id);
         end
      end
   end

   always_comb begin
      tail_src = head;
      if (state_ff == S_INSERT && CNT_W'(step_ff) == count_ff) begin
         tail_src = key_ff;
      end
   end

   // ring, head at cell 0: cells take the upper neighbor; head or new key wraps to top
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i < QUEUE_DEPTH - 2) begin : g_mid
         assign cell_next[i] = cell_q[i+1];
         assign cell_en[i]   = shift_en;
      end else if (i == QUEUE_DEPTH - 2) begin : g_pen
         assign cell_next[i] = short_ring ? head : cell_q[QUEUE_DEPTH-1];
         assign cell_en[i]   = shift_en;
      end else begin : g_tail
         assign cell_next[i] = tail_src;
         assign cell_en[i]   = shift_en && !short_ring;
      end

      mprq_cell u_cell (
         .clock    (clock),
         .shift_en (cell_en[i]),
         .d_next   (cell_next[i]),
         .q        (cell_q[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_ENQ:   state_in = (count_ff == FULL_CNT) ? S_DONE : S_INSERT;
                  OP_DEQ:   state_in = (count_ff == '0) ? S_DONE : S_SCAN;
                  OP_PURGE: state_in = (count_ff == '0) ? S_DONE : S_REMOVE;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (last_step) begin
               state_in = S_REMOVE;
            end
         end
         S_REMOVE, S_INSERT: begin
            if (last_step) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      step_in       = step_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      if (shift_en) begin
         step_in = last_step ? '0 : step_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               key_in.id     = req_tdata[ID_W-1:0];
               key_in.prio   = req_tdata[ID_W+PRIO_W-1:ID_W];
               step_in       = '0;
               found_in      = 1'b0;
               res_entry_in  = '0;
               res_status_in = ST_DONE;
               if (req_op == OP_ENQ && count_ff == FULL_CNT) begin
                  res_status_in = ST_FULL;
               end else if ((req_op == OP_DEQ || req_op == OP_PURGE) &&
                            count_ff == '0) begin
                  res_status_in = ST_MISS;
               end
            end
         end
         S_SCAN: begin
            if (step_live && (step_ff == '0 || head.prio < best_prio_ff)) begin
               best_idx_in  = step_ff;
               best_prio_in = head.prio;
            end
         end
         S_REMOVE: begin
            if (drop_now) begin
               found_in     = 1'b1;
               res_entry_in = head;
            end
            if (last_step) begin
               if (found_ff || drop_now) begin
                  count_in      = count_ff - 1'b1;
                  res_status_in = ST_DONE;
               end else begin
                  res_status_in = ST_MISS;
               end
            end
         end
         S_INSERT: begin
            if (last_step) begin
               count_in = count_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = RSP_W'({(count_ff == '0), count_ff,
                                       res_entry_ff.prio, res_entry_ff.id});
            end
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      best_idx_ff   <= best_idx_in;
      best_prio_ff  <= best_prio_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
